[design/icr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icr_pkg
// Shared types, constants and helpers for the impulse collision resolver.
// ----------------------------------------------------------------------------
package icr_pkg;

    // Number of register stages from the input register to the output register.
    localparam int unsigned NUM_STAGES = 23;
    // Width of the quotient produced by the weight divider.
    localparam int unsigned QUO_W      = 16;
    // First and last stage of the divider's steps; the divider is loaded in stage 1.
    localparam int unsigned DIV_FIRST  = 2;
    localparam int unsigned DIV_LAST   = DIV_FIRST + QUO_W - 1;

    localparam logic [16:0] ONE_Q16 = 17'd65536;

    // Everything one request carries down the pipeline.
    typedef struct packed {
        logic signed [31:0] vax;
        logic signed [31:0] vay;
        logic signed [31:0] vbx;
        logic signed [31:0] vby;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic        [16:0] ra;
        logic        [16:0] rb;
        logic        [31:0] ma;
        logic        [31:0] mb;
        logic signed [32:0] rvx;
        logic signed [32:0] rvy;
        logic        [17:0] k;
        logic               st_a;
        logic               st_b;
        logic        [32:0] rem;
        logic        [32:0] dsr;
        logic        [15:0] quo;
        logic signed [48:0] px;
        logic signed [48:0] py;
        logic signed [49:0] vn;
        logic               skip;
        logic        [35:0] mq;
        logic        [37:0] q;
        logic        [16:0] wa;
        logic        [16:0] wb;
        logic        [38:0] qa;
        logic        [38:0] qb;
        logic signed [54:0] pax;
        logic signed [54:0] pay;
        logic signed [54:0] pbx;
        logic signed [54:0] pby;
        logic signed [40:0] dax;
        logic signed [40:0] day;
        logic signed [40:0] dbx;
        logic signed [40:0] dby;
        logic signed [31:0] ova_x;
        logic signed [31:0] ova_y;
        logic signed [31:0] ovb_x;
        logic signed [31:0] ovb_y;
        logic               res;
    } t_stage;

    // Clamp a wide signed sum to the signed 32-bit range.
    function automatic logic signed [31:0] sat32(input logic signed [41:0] x);
        logic signed [31:0] y;
        if (x > 42'sd2147483647) begin
            y = 32'sh7FFFFFFF;
        end else if (x < -42'sd2147483648) begin
            y = 32'sh80000000;
        end else begin
            y = x[31:0];
        end
        return y;
    endfunction

endpackage

[design/impulse_collision_resolver.sv]
`timescale 1ns / 1ps
// An accepted request moves from the input register through every stage to the output register.
// Throughput: one request per cycle while the output is not stalled; the weight divider is a 16-stage
// pipeline with one quotient bit per stage, so it never blocks the stream.
// Reset: synchronous, active low; clears all stage valid bits only.
// A stalled output holds its result; empty stages upstream still fill.
// ----------------------------------------------------------------------------
// impulse_collision_resolver
// Impulse-based 2D collision response for one colliding pair per request.
// ----------------------------------------------------------------------------
module impulse_collision_resolver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_vel_a_x,
    input  logic [31:0] i_vel_a_y,
    input  logic [31:0] i_vel_b_x,
    input  logic [31:0] i_vel_b_y,
    input  logic [15:0] i_normal_x,
    input  logic [15:0] i_normal_y,
    input  logic [16:0] i_rest_a,
    input  logic [16:0] i_rest_b,
    input  logic [31:0] i_mass_a,
    input  logic [31:0] i_mass_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_new_vel_a_x,
    output logic [31:0] o_new_vel_a_y,
    output logic [31:0] o_new_vel_b_x,
    output logic [31:0] o_new_vel_b_y,
    output logic        o_resolved
);
    import icr_pkg::*;

    localparam int unsigned LAST = NUM_STAGES - 1;

    t_stage r_st  [NUM_STAGES];
    t_stage n_st  [NUM_STAGES];
    logic   r_vld [NUM_STAGES];
    logic   adv   [NUM_STAGES];

    // A stage may load when it is empty or its content moves on.
    always_comb begin
        adv[LAST] = !r_vld[LAST] || !i_stall;
        for (int i = LAST - 1; i >= 0; i--) begin
            adv[i] = !r_vld[i] || adv[i + 1];
        end
    end

    assign o_stall = !adv[0];

    // Per-stage datapath.
    always_comb begin
        logic [33:0] rem2;
        logic [49:0] negm;
        logic [53:0] prod_mk;
        logic [54:0] prod_a;
        logic [54:0] prod_b;

        rem2    = '0;
        negm    = '0;
        prod_mk = '0;
        prod_a  = '0;
        prod_b  = '0;

        // Input register.
        n_st[0]     = r_st[0];
        n_st[0].vax = i_vel_a_x;
        n_st[0].vay = i_vel_a_y;
        n_st[0].vbx = i_vel_b_x;
        n_st[0].vby = i_vel_b_y;
        n_st[0].nx  = i_normal_x;
        n_st[0].ny  = i_normal_y;
        n_st[0].ra  = i_rest_a;
        n_st[0].rb  = i_rest_b;
        n_st[0].ma  = i_mass_a;
        n_st[0].mb  = i_mass_b;

        for (int i = 1; i < NUM_STAGES; i++) begin
            n_st[i] = r_st[i - 1];
        end

        // Stage 1: relative velocity, restitution factor, divider load.
        n_st[1].rvx  = 33'(r_st[0].vbx) - 33'(r_st[0].vax);
        n_st[1].rvy  = 33'(r_st[0].vby) - 33'(r_st[0].vay);
        n_st[1].k    = 18'(ONE_Q16) +
                       18'((r_st[0].ra < r_st[0].rb) ? r_st[0].ra : r_st[0].rb);
        n_st[1].st_a = (r_st[0].ma == 32'd0);
        n_st[1].st_b = (r_st[0].mb == 32'd0);
        n_st[1].rem  = {1'b0, r_st[0].mb};
        n_st[1].dsr  = 33'(r_st[0].ma) + 33'(r_st[0].mb);
        n_st[1].quo  = '0;

        // Stage 2: projections on the normal.
        n_st[2].px = 49'(r_st[1].rvx) * 49'(r_st[1].nx);
        n_st[2].py = 49'(r_st[1].rvy) * 49'(r_st[1].ny);

        // Stage 3: normal speed and the pass-through decision.
        n_st[3].vn   = 50'(r_st[2].px) + 50'(r_st[2].py);
        n_st[3].skip = (50'(r_st[2].px) + 50'(r_st[2].py) > 50'sd0)
                       || (r_st[2].st_a && r_st[2].st_b);

        // Stage 4: closing speed magnitude, rescaled.
        negm       = 50'(-r_st[3].vn);
        n_st[4].mq = negm[49:14];

        // Stage 5: impulse per unit mass.
        prod_mk   = 54'(r_st[4].mq) * 54'(r_st[4].k);
        n_st[5].q = prod_mk[53:16];

        // Divider steps: one quotient bit of mB*2^16 / (mA+mB) per stage.
        for (int i = DIV_FIRST; i <= DIV_LAST; i++) begin
            rem2 = {r_st[i - 1].rem, 1'b0};
            if (rem2 >= {1'b0, r_st[i - 1].dsr}) begin
                n_st[i].rem = 33'(rem2 - {1'b0, r_st[i - 1].dsr});
                n_st[i].quo = {r_st[i - 1].quo[QUO_W-2:0], 1'b1};
            end else begin
                n_st[i].rem = rem2[32:0];
                n_st[i].quo = {r_st[i - 1].quo[QUO_W-2:0], 1'b0};
            end
        end

        // Mass weights; B's weight follows from A's quotient and remainder.
        if (r_st[DIV_LAST].st_a) begin
            n_st[DIV_LAST+1].wa = '0;
            n_st[DIV_LAST+1].wb = ONE_Q16;
        end else if (r_st[DIV_LAST].st_b) begin
            n_st[DIV_LAST+1].wa = ONE_Q16;
            n_st[DIV_LAST+1].wb = '0;
        end else begin
            n_st[DIV_LAST+1].wa = {1'b0, r_st[DIV_LAST].quo};
            if (r_st[DIV_LAST].rem != 33'd0) begin
                n_st[DIV_LAST+1].wb = ONE_Q16 - 17'd1 - {1'b0, r_st[DIV_LAST].quo};
            end else begin
                n_st[DIV_LAST+1].wb = ONE_Q16 - {1'b0, r_st[DIV_LAST].quo};
            end
        end

        // Weighted impulse per body.
        prod_a = 55'(r_st[DIV_LAST+1].q) * 55'(r_st[DIV_LAST+1].wa);
        prod_b = 55'(r_st[DIV_LAST+1].q) * 55'(r_st[DIV_LAST+1].wb);
        n_st[DIV_LAST+2].qa = prod_a[54:16];
        n_st[DIV_LAST+2].qb = prod_b[54:16];

        // Impulse vectors along the normal.
        n_st[DIV_LAST+3].pax = 55'($signed({1'b0, r_st[DIV_LAST+2].qa})) *
                               55'(r_st[DIV_LAST+2].nx);
        n_st[DIV_LAST+3].pay = 55'($signed({1'b0, r_st[DIV_LAST+2].qa})) *
                               55'(r_st[DIV_LAST+2].ny);
        n_st[DIV_LAST+3].pbx = 55'($signed({1'b0, r_st[DIV_LAST+2].qb})) *
                               55'(r_st[DIV_LAST+2].nx);
        n_st[DIV_LAST+3].pby = 55'($signed({1'b0, r_st[DIV_LAST+2].qb})) *
                               55'(r_st[DIV_LAST+2].ny);

        // Scale back to Q16.16, rounding toward zero.
        n_st[DIV_LAST+4].dax = 41'((r_st[DIV_LAST+3].pax + ((r_st[DIV_LAST+3].pax < 0) ?
                               55'sd16383 : 55'sd0)) >>> 14);
        n_st[DIV_LAST+4].day = 41'((r_st[DIV_LAST+3].pay + ((r_st[DIV_LAST+3].pay < 0) ?
                               55'sd16383 : 55'sd0)) >>> 14);
        n_st[DIV_LAST+4].dbx = 41'((r_st[DIV_LAST+3].pbx + ((r_st[DIV_LAST+3].pbx < 0) ?
                               55'sd16383 : 55'sd0)) >>> 14);
        n_st[DIV_LAST+4].dby = 41'((r_st[DIV_LAST+3].pby + ((r_st[DIV_LAST+3].pby < 0) ?
                               55'sd16383 : 55'sd0)) >>> 14);

        // Output stage: apply the impulse and saturate, or pass through.
        if (r_st[LAST-1].skip) begin
            n_st[LAST].ova_x = r_st[LAST-1].vax;
            n_st[LAST].ova_y = r_st[LAST-1].vay;
            n_st[LAST].ovb_x = r_st[LAST-1].vbx;
            n_st[LAST].ovb_y = r_st[LAST-1].vby;
            n_st[LAST].res   = 1'b0;
        end else begin
            n_st[LAST].ova_x = sat32(42'(r_st[LAST-1].vax) - 42'(r_st[LAST-1].dax));
            n_st[LAST].ova_y = sat32(42'(r_st[LAST-1].vay) - 42'(r_st[LAST-1].day));
            n_st[LAST].ovb_x = sat32(42'(r_st[LAST-1].vbx) + 42'(r_st[LAST-1].dbx));
            n_st[LAST].ovb_y = sat32(42'(r_st[LAST-1].vby) + 42'(r_st[LAST-1].dby));
            n_st[LAST].res   = 1'b1;
        end
    end

    // Stage valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_STAGES; i++) begin
                r_vld[i] <= 1'b0;
            end
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (adv[i]) begin
                    r_vld[i] <= r_vld[i - 1];
                end
            end
        end
    end

    // Stage payload registers.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_STAGES; i++) begin
            if (adv[i]) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    assign o_valid       = r_vld[LAST];
    assign o_new_vel_a_x = r_st[LAST].ova_x;
    assign o_new_vel_a_y = r_st[LAST].ova_y;
    assign o_new_vel_b_x = r_st[LAST].ovb_x;
    assign o_new_vel_b_y = r_st[LAST].ovb_y;
    assign o_resolved    = r_st[LAST].res;

endmodule

[tb/impulse_collision_resolver_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// impulse_collision_resolver_tb
// Drives colliding pairs into the resolver with random idling on both sides,
// predicts each response in fixed point and compares every output field.
// ----------------------------------------------------------------------------

// Holds the predicted responses in request order and checks them.
class response_board;
    typedef struct {
        logic [31:0] vax, vay, vbx, vby;
        logic        res;
    } t_response;

    t_response pending[$];
    int        errors;

    function automatic logic [31:0] clamp32(longint x);
        if (x > 64'sd2147483647) return 32'h7FFFFFFF;
        if (x < -64'sd2147483648) return 32'h80000000;
        return x[31:0];
    endfunction

    // Works out the response to one accepted request.
    function void note_request(logic [31:0] vax, logic [31:0] vay,
                               logic [31:0] vbx, logic [31:0] vby,
                               logic [15:0] nx, logic [15:0] ny,
                               logic [16:0] ra, logic [16:0] rb,
                               logic [31:0] ma, logic [31:0] mb);
        longint    ax, ay, bx, by, sx, sy, vn, sa, sb;
        longint unsigned mag, k, q, wa, wb, tot;
        t_response r;
        ax = $signed(vax); ay = $signed(vay);
        bx = $signed(vbx); by = $signed(vby);
        sx = $signed(nx);  sy = $signed(ny);
        vn = (bx - ax) * sx + (by - ay) * sy;
        r.vax = vax; r.vay = vay; r.vbx = vbx; r.vby = vby; r.res = 1'b0;
        if (!(vn > 0 || (ma == 0 && mb == 0))) begin
            mag = -vn;
            k = 65536 + ((ra < rb) ? ra : rb);
            q = ((mag >> 14) * k) >> 16;
            if (ma == 0) begin
                wa = 0; wb = 65536;
            end else if (mb == 0) begin
                wa = 65536; wb = 0;
            end else begin
                tot = longint'(ma) + longint'(mb);
                wa = (longint'(mb) << 16) / tot;
                wb = (longint'(ma) << 16) / tot;
            end
            sa = (q * wa) >> 16;
            sb = (q * wb) >> 16;
            r.vax = clamp32(ax - (sa * sx) / 16384);
            r.vay = clamp32(ay - (sa * sy) / 16384);
            r.vbx = clamp32(bx + (sb * sx) / 16384);
            r.vby = clamp32(by + (sb * sy) / 16384);
            r.res = 1'b1;
        end
        pending = {pending, r};
    endfunction

    task report(string what);
        errors++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // Compares one accepted response with the oldest prediction.
    task check_response(logic [31:0] vax, logic [31:0] vay, logic [31:0] vbx,
                        logic [31:0] vby, logic res);
        t_response e;
        if (pending.size() == 0) begin
            report("response with no request outstanding");
            return;
        end
        e = pending.pop_front();
        if (vax !== e.vax) report($sformatf("vel_a_x %h exp %h", vax, e.vax));
        if (vay !== e.vay) report($sformatf("vel_a_y %h exp %h", vay, e.vay));
        if (vbx !== e.vbx) report($sformatf("vel_b_x %h exp %h", vbx, e.vbx));
        if (vby !== e.vby) report($sformatf("vel_b_y %h exp %h", vby, e.vby));
        if (res !== e.res) report($sformatf("resolved %b exp %b", res, e.res));
    endtask
endclass

module impulse_collision_resolver_tb;
    import icr_pkg::*;

    logic        clk, rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    logic [31:0] vel_a_x, vel_a_y, vel_b_x, vel_b_y, mass_a, mass_b;
    logic [15:0] normal_x, normal_y;
    logic [16:0] rest_a, rest_b;
    logic [31:0] new_a_x, new_a_y, new_b_x, new_b_y;
    logic        resolved;

    int sender_idle_pct, receiver_idle_pct;
    int hold_cycles;
    response_board board;

    impulse_collision_resolver dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_vel_a_x(vel_a_x), .i_vel_a_y(vel_a_y),
        .i_vel_b_x(vel_b_x), .i_vel_b_y(vel_b_y),
        .i_normal_x(normal_x), .i_normal_y(normal_y),
        .i_rest_a(rest_a), .i_rest_b(rest_b),
        .i_mass_a(mass_a), .i_mass_b(mass_b),
        .o_valid(out_valid), .i_stall(out_stall),
        .o_new_vel_a_x(new_a_x), .o_new_vel_a_y(new_a_y),
        .o_new_vel_b_x(new_b_x), .o_new_vel_b_y(new_b_y),
        .o_resolved(resolved)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial begin
        #50ms;
        $display("[impulse_collision_resolver] ERROR");
        $finish;
    end

    // Offers one request, idling first at random, and waits for acceptance.
    task send_pair(logic [31:0] vax, logic [31:0] vay, logic [31:0] vbx,
                   logic [31:0] vby, logic [15:0] nx, logic [15:0] ny,
                   logic [16:0] ra, logic [16:0] rb,
                   logic [31:0] ma, logic [31:0] mb);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        vel_a_x <= vax; vel_a_y <= vay; vel_b_x <= vbx; vel_b_y <= vby;
        normal_x <= nx; normal_y <= ny; rest_a <= ra; rest_b <= rb;
        mass_a <= ma; mass_b <= mb;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        board.note_request(vax, vay, vbx, vby, nx, ny, ra, rb, ma, mb);
    endtask

    // Picks an extreme of a given width or a random value.
    function automatic logic [31:0] pick_value(int w);
        logic [31:0] v;
        v = $urandom();
        case ($urandom_range(9))
            0: v = 0;
            1: v = '1;
            2: v = 32'h1 << (w - 1);
            3: v = ~(32'h1 << (w - 1));
            4: v = 32'($signed(16'($urandom_range(65535) - 32768)));
            default: ;
        endcase
        return v;
    endfunction

    // A random pair along a near-unit normal, sometimes with noise in every field.
    task send_random_pair();
        logic [15:0] nx, ny;
        logic [31:0] vax, vay, vbx, vby, ma, mb;
        logic [16:0] ra, rb;
        int ang;
        ang = $urandom_range(7);
        nx = (ang % 3 == 0) ? 16'sd16384 : (ang % 3 == 1) ? 16'sd11585 : 16'sd0;
        ny = (ang % 3 == 0) ? 16'sd0 : (ang % 3 == 1) ? 16'sd11585 : 16'sd16384;
        if (ang[2]) begin
            nx = -nx; ny = -ny;
        end
        vax = $urandom() >> $urandom_range(31); vay = $urandom() >> $urandom_range(31);
        vbx = $urandom() >> $urandom_range(31); vby = $urandom() >> $urandom_range(31);
        if ($urandom_range(1)) vax = -vax;
        if ($urandom_range(1)) vby = -vby;
        ra = 17'($urandom_range(65536)); rb = 17'($urandom_range(65536));
        ma = $urandom() >> $urandom_range(31); mb = $urandom() >> $urandom_range(31);
        if ($urandom_range(9) == 0) ma = 0;
        if ($urandom_range(9) == 0) mb = 0;
        if ($urandom_range(4) == 0) begin
            // Noise: any field at any value.
            nx = 16'(pick_value(16)); ny = 16'(pick_value(16));
            vax = pick_value(32); vay = pick_value(32);
            vbx = pick_value(32); vby = pick_value(32);
            ra = 17'($urandom()); rb = 17'($urandom());
            ma = pick_value(32); mb = pick_value(32);
        end
        send_pair(vax, vay, vbx, vby, nx, ny, ra, rb, ma, mb);
    endtask

    // Receiver side: random stall, plus one long hold-off on request.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < receiver_idle_pct);
        end
    end

    // Response check on every accepted output.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall)
            board.check_response(new_a_x, new_a_y, new_b_x, new_b_y, resolved);
    end

    initial begin
        int waited;
        board = new();
        rst_n = 1'b0; in_valid = 1'b0; hold_cycles = 0;
        vel_a_x = 0; vel_a_y = 0; vel_b_x = 0; vel_b_y = 0;
        normal_x = 0; normal_y = 0; rest_a = 0; rest_b = 0;
        mass_a = 0; mass_b = 0;
        sender_idle_pct = 30; receiver_idle_pct = 81;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: head-on, separating, both static, one static, zero speed,
        // restitution above one, odd normals and saturating extremes.
        send_pair(32'h0001_0000, 0, 32'hFFFF_0000, 0, 16'sd16384, 0,
                  17'd65536, 17'd65536, 32'h0001_0000, 32'h0001_0000);
        send_pair(32'hFFFF_0000, 0, 32'h0001_0000, 0, 16'sd16384, 0,
                  17'd0, 17'd0, 32'h0001_0000, 32'h0001_0000);
        send_pair(32'h0001_0000, 0, 32'hFFFF_0000, 0, 16'sd16384, 0,
                  17'd0, 17'd0, 0, 0);
        send_pair(32'h0001_0000, 0, 32'hFFFF_0000, 0, 16'sd16384, 0,
                  17'd32768, 17'd0, 0, 32'h0002_0000);
        send_pair(32'h0001_0000, 0, 32'hFFFF_0000, 0, 16'sd16384, 0,
                  17'd32768, 17'd0, 32'h0002_0000, 0);
        send_pair(32'h0003_0000, 32'h0005_0000, 32'h0003_0000, 32'h0005_0000,
                  16'sd11585, 16'sd11585, 17'd1000, 17'd2000, 32'h1, 32'h1);
        send_pair(32'h0001_0000, 0, 32'hFFFF_0000, 0, 16'sd16384, 0,
                  17'h1FFFF, 17'h1FFFF, 32'h0001_0000, 32'h0003_0000);
        send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
                  16'h7FFF, 16'h7FFF, 17'h1FFFF, 17'h1FFFF,
                  32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  16'h8000, 16'h8000, 17'd65536, 17'd65536,
                  32'h1, 32'hFFFF_FFFF);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  16'h8000, 16'h7FFF, 17'd0, 17'd65536, 0, 32'hFFFF_FFFF);
        send_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 16'h7FFF, 16'h8000,
                  17'h1FFFF, 17'h0, 32'hFFFF_FFFF, 0);
        send_pair(32'h0, 32'h0, 32'h0, 32'h0, 16'h0, 16'h0,
                  17'h1FFFF, 17'h1FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // Long receiver hold-off while requests keep coming.
        sender_idle_pct = 0;
        hold_cycles = 80;
        repeat (60) send_random_pair();

        // Random phases with different idling mixes.
        sender_idle_pct = 30; receiver_idle_pct = 81;
        repeat (330) send_random_pair();
        sender_idle_pct = 81; receiver_idle_pct = 30;
        repeat (330) send_random_pair();
        sender_idle_pct = 0; receiver_idle_pct = 0;
        repeat (330) send_random_pair();
        in_valid <= 1'b0;

        waited = 0;
        while (board.pending.size() != 0 && waited < 20000) begin
            @(posedge clk);
            waited++;
        end
        repeat (30) @(posedge clk);
        if (board.pending.size() != 0)
            board.report("responses missing at end of run");
        if (board.errors == 0)
            $display("[impulse_collision_resolver] OK");
        else
            $display("[impulse_collision_resolver] ERROR");
        $finish;
    end
endmodule
